// File: sv/touch_stroke_line_plotter_macros.svh
// Assertion macros for the touch stroke line plotter checker.
// Every macro samples on clk; the first two are muted while rst_n is low.
`ifndef TOUCH_STROKE_LINE_PLOTTER_MACROS_SVH
`define TOUCH_STROKE_LINE_PLOTTER_MACROS_SVH

// Same-cycle implication, muted during reset
`define TSP_CHK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset
`define TSP_CHK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied
`define TSP_CHK_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tsp_pkg.sv
// Shared types and constants of the touch stroke line plotter.
// Used by the front, queue, back, top level and checker; no dependencies.
package tsp_pkg;

  // Cell coordinate width on the result channel
  localparam int CELL_W      = 6;
  localparam int TOUCH_W     = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Input item kinds
  localparam logic [1:0] KIND_HELD    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic REG_ORIGIN_X = 1'b0;
  localparam logic REG_ORIGIN_Y = 1'b1;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [1:0] {
    OP_HELD,
    OP_END,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
  } cmd_t;

  typedef enum logic [3:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_START_RD,
    B_START_CHK,
    B_DIV,
    B_STEP_RD,
    B_STEP_CHK,
    B_END_EMIT
  } back_state_t;

endpackage

// File: sv/tsp_front.sv
// Front end: origin registers, input handshake and sample classification.
// Depends on tsp_pkg; feeds commands into tsp_fifo.
module tsp_front #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [tsp_pkg::TOUCH_W-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [1:0]                  in_kind,
  input  logic [tsp_pkg::TOUCH_W-1:0] in_x,
  input  logic [tsp_pkg::TOUCH_W-1:0] in_y,
  input  logic                        init_busy,
  input  logic                        q_full,
  output logic                        push,
  output tsp_pkg::cmd_t               push_cmd
);

  localparam logic [tsp_pkg::TOUCH_W-1:0] LIM_X = tsp_pkg::TOUCH_W'(GRID_W - 1);
  localparam logic [tsp_pkg::TOUCH_W-1:0] LIM_Y = tsp_pkg::TOUCH_W'(GRID_H - 1);

  logic [tsp_pkg::TOUCH_W-1:0] origin_x_r;
  logic [tsp_pkg::TOUCH_W-1:0] origin_y_r;
  logic [tsp_pkg::TOUCH_W:0]   off_x;
  logic [tsp_pkg::TOUCH_W:0]   off_y;
  logic                        in_region;
  logic                        accept;

  // Origin registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tsp_pkg::REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        tsp_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // No items during the canvas clearing pass after reset
  assign in_tready = !init_busy && !q_full;
  assign accept    = in_tvalid && in_tready;

  // Region test: borrow means left of origin
  assign off_x     = {1'b0, in_x} - {1'b0, origin_x_r};
  assign off_y     = {1'b0, in_y} - {1'b0, origin_y_r};
  assign in_region = !off_x[tsp_pkg::TOUCH_W] && !off_y[tsp_pkg::TOUCH_W] &&
                     (off_x[tsp_pkg::TOUCH_W-1:0] < LIM_X) &&
                     (off_y[tsp_pkg::TOUCH_W-1:0] < LIM_Y);

  // Kind decoder
  always_comb begin
    push_cmd.cx = tsp_pkg::CELL_W'(off_x[tsp_pkg::TOUCH_W-1:1]);
    push_cmd.cy = tsp_pkg::CELL_W'(off_y[tsp_pkg::TOUCH_W-1:1]);
    push_cmd.op = tsp_pkg::OP_END;
    push        = 1'b0;
    unique case (in_kind)
      tsp_pkg::KIND_HELD: begin
        push        = accept;
        push_cmd.op = in_region ? tsp_pkg::OP_HELD : tsp_pkg::OP_END;
      end
      tsp_pkg::KIND_RELEASE: begin
        push        = accept;
        push_cmd.op = tsp_pkg::OP_END;
      end
      tsp_pkg::KIND_CLEAR: begin
        push        = accept;
        push_cmd.op = tsp_pkg::OP_CLEAR;
      end
      default: push = 1'b0;
    endcase
  end

endmodule

// File: sv/tsp_fifo.sv
// Two-entry command queue between the front end and the line engine.
// Depends on tsp_pkg for the command type and depth.
module tsp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsp_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          cmd_valid,
  output tsp_pkg::cmd_t cmd,
  input  logic          pop
);

  tsp_pkg::cmd_t            slot_r [tsp_pkg::QDEPTH];
  logic [tsp_pkg::QAW-1:0]  wp_r;
  logic [tsp_pkg::QAW-1:0]  rp_r;
  logic [tsp_pkg::QAW:0]    cnt_r;
  logic                     do_push;
  logic                     do_pop;

  assign full      = (cnt_r == (tsp_pkg::QAW+1)'(tsp_pkg::QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = slot_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && cmd_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_cmd;
  end

endmodule

// File: sv/tsp_div.sv
// Restoring divider, one quotient bit per cycle, for the minor-axis step.
// Computes (num << FRAC_BITS) / den; depends on tsp_pkg for CELL_W.
module tsp_div #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [tsp_pkg::CELL_W-1:0]            num,
  input  logic [tsp_pkg::CELL_W-1:0]            den,
  output logic                                  done,
  output logic [tsp_pkg::CELL_W+FRAC_BITS-1:0]  quo
);

  localparam int DW = tsp_pkg::CELL_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [DW-1:0]               dvd_r;
  logic [tsp_pkg::CELL_W-1:0]  rem_r;
  logic [tsp_pkg::CELL_W-1:0]  den_r;
  logic [tsp_pkg::CELL_W:0]    shl;
  logic                        ge;

  // Trial subtraction
  assign shl = {rem_r, dvd_r[DW-1]};
  assign ge  = (shl >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) busy_r <= 1'b0;
      end
    end
  end

  // Quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? tsp_pkg::CELL_W'(shl - {1'b0, den_r})
                  : shl[tsp_pkg::CELL_W-1:0];
      dvd_r <= {dvd_r[DW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = dvd_r;

endmodule

// File: sv/tsp_back.sv
// Line engine: canvas memory, stroke state, DDA stepping and result register.
// Depends on tsp_pkg and tsp_div; takes commands from tsp_fifo.
module tsp_back #(
  parameter int GRID_W    = 64,
  parameter int GRID_H    = 64,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  tsp_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        init_busy,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tsp_pkg::CELL_W-1:0]  out_cx,
  output logic [tsp_pkg::CELL_W-1:0]  out_cy,
  output logic                        out_last
);

  localparam int CW = tsp_pkg::CELL_W;
  localparam int AW = $clog2(GRID_W);
  localparam int HB = $clog2(GRID_H);
  localparam int DW = CW + FRAC_BITS;
  localparam int SW = DW + 1;
  localparam int PW = DW + 2;
  localparam logic [CW:0]   GW_C  = (CW+1)'(GRID_W);
  localparam logic [CW:0]   GH_C  = (CW+1)'(GRID_H);
  localparam logic [AW-1:0] SW_END = AW'(GRID_W - 1);

  tsp_pkg::back_state_t state_r, state_nxt;

  // Canvas: one row of GRID_H bits per column x
  logic [GRID_H-1:0] canvas_mem [GRID_W];
  logic [GRID_H-1:0] rd_row_r;

  logic              drawing_r;
  logic [CW-1:0]     last_x_r, last_y_r;
  logic [CW-1:0]     tgt_x_r, tgt_y_r;
  logic [CW-1:0]     cur_x_r, cur_y_r;
  logic [AW-1:0]     sweep_r;
  logic              xmajor_r, dir_neg_r, mneg_r;
  logic [CW:0]       p_r;
  logic [PW-1:0]     pos_r;
  logic [SW-1:0]     step_r;
  logic [CW-1:0]     cnt_r;
  logic              out_tvalid_r, out_last_r;
  logic [CW-1:0]     out_cx_r, out_cy_r;

  // Line setup from the popped command and the last cell
  logic [CW:0]       dx, dy;
  logic [CW-1:0]     adx, ady, major_c, mabs_c, mstart_c, pstart_c;
  logic              xmaj_c, mneg_c, dneg_c, same_c;

  // Stepping
  logic [CW:0]       m_pos, cand_x, cand_y;
  logic              cand_ok, last_step, row_hit, out_free, sweep_last;
  logic [DW-1:0]     div_q;
  logic              div_done;
  logic [SW-1:0]     step_c;

  // Controls
  logic              mem_we, mem_re, emit, emit_last, div_start, adv;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [GRID_H-1:0] mem_wdata;
  logic [CW-1:0]     emit_x, emit_y;

  assign out_free   = !out_tvalid_r || out_tready;
  assign sweep_last = (sweep_r == SW_END);
  assign init_busy  = (state_r == tsp_pkg::B_INIT);
  assign last_step  = (cnt_r == CW'(1));
  assign row_hit    = rd_row_r[cur_y_r[HB-1:0]];

  // Differences, major axis and direction
  assign dx       = {1'b0, cmd.cx} - {1'b0, last_x_r};
  assign dy       = {1'b0, cmd.cy} - {1'b0, last_y_r};
  assign adx      = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ady      = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign xmaj_c   = (adx > ady);
  assign major_c  = xmaj_c ? adx : ady;
  assign mabs_c   = xmaj_c ? ady : adx;
  assign mneg_c   = xmaj_c ? dy[CW] : dx[CW];
  assign dneg_c   = xmaj_c ? dx[CW] : dy[CW];
  assign mstart_c = xmaj_c ? last_y_r : last_x_r;
  assign pstart_c = xmaj_c ? last_x_r : last_y_r;
  assign same_c   = (cmd.cx == last_x_r) && (cmd.cy == last_y_r);

  // Signed step from the unsigned quotient
  assign step_c = mneg_r ? SW'(~{1'b0, div_q} + 1'b1) : {1'b0, div_q};

  // Current intermediate cell
  assign m_pos   = pos_r[PW-2:FRAC_BITS];
  assign cand_x  = xmajor_r ? p_r : m_pos;
  assign cand_y  = xmajor_r ? m_pos : p_r;
  assign cand_ok = !pos_r[PW-1] && !p_r[CW] && (cand_x < GW_C) && (cand_y < GH_C);

  tsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mabs_c),
    .den   (major_c),
    .done  (div_done),
    .quo   (div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsp_pkg::B_INIT, tsp_pkg::B_CLEAR: begin
        if (sweep_last) state_nxt = tsp_pkg::B_IDLE;
      end
      tsp_pkg::B_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            tsp_pkg::OP_CLEAR: state_nxt = tsp_pkg::B_CLEAR;
            tsp_pkg::OP_HELD: begin
              if (!drawing_r)   state_nxt = tsp_pkg::B_START_RD;
              else if (!same_c) state_nxt = tsp_pkg::B_DIV;
            end
            default: state_nxt = tsp_pkg::B_IDLE;
          endcase
        end
      end
      tsp_pkg::B_START_RD: state_nxt = tsp_pkg::B_START_CHK;
      tsp_pkg::B_START_CHK: begin
        if (row_hit || out_free) state_nxt = tsp_pkg::B_IDLE;
      end
      tsp_pkg::B_DIV: begin
        if (div_done) begin
          state_nxt = (cnt_r == '0) ? tsp_pkg::B_END_EMIT : tsp_pkg::B_STEP_RD;
        end
      end
      tsp_pkg::B_STEP_RD: begin
        if (cand_ok)        state_nxt = tsp_pkg::B_STEP_CHK;
        else if (last_step) state_nxt = tsp_pkg::B_END_EMIT;
      end
      tsp_pkg::B_STEP_CHK: begin
        if (row_hit || out_free) begin
          state_nxt = last_step ? tsp_pkg::B_END_EMIT : tsp_pkg::B_STEP_RD;
        end
      end
      tsp_pkg::B_END_EMIT: begin
        if (out_free) state_nxt = tsp_pkg::B_IDLE;
      end
      default: state_nxt = tsp_pkg::B_IDLE;
    endcase
  end

  // Per-state controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_x_r[AW-1:0];
    mem_wdata = rd_row_r | (GRID_H'(1) << cur_y_r[HB-1:0]);
    mem_re    = 1'b0;
    mem_raddr = cand_x[AW-1:0];
    emit      = 1'b0;
    emit_x    = cur_x_r;
    emit_y    = cur_y_r;
    emit_last = 1'b0;
    cmd_pop   = 1'b0;
    div_start = 1'b0;
    adv       = 1'b0;
    unique case (state_r)
      tsp_pkg::B_INIT, tsp_pkg::B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = '0;
      end
      tsp_pkg::B_IDLE: begin
        cmd_pop   = cmd_valid;
        div_start = cmd_valid && (cmd.op == tsp_pkg::OP_HELD) && drawing_r && !same_c;
      end
      tsp_pkg::B_START_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cur_x_r[AW-1:0];
      end
      tsp_pkg::B_START_CHK: begin
        if (!row_hit && out_free) begin
          mem_we    = 1'b1;
          emit      = 1'b1;
          emit_last = 1'b1;
        end
      end
      tsp_pkg::B_STEP_RD: begin
        if (cand_ok) mem_re = 1'b1;
        else         adv    = 1'b1;
      end
      tsp_pkg::B_STEP_CHK: begin
        if (row_hit) begin
          adv = 1'b1;
        end else if (out_free) begin
          mem_we = 1'b1;
          emit   = 1'b1;
          adv    = 1'b1;
        end
      end
      tsp_pkg::B_END_EMIT: begin
        emit      = out_free;
        emit_x    = tgt_x_r;
        emit_y    = tgt_y_r;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Canvas memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) canvas_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_row_r <= canvas_mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsp_pkg::B_INIT;
      sweep_r      <= '0;
      drawing_r    <= 1'b0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we && (state_r == tsp_pkg::B_INIT || state_r == tsp_pkg::B_CLEAR)) begin
        sweep_r <= sweep_last ? '0 : sweep_r + 1'b1;
      end
      if (cmd_pop && cmd.op == tsp_pkg::OP_END) drawing_r <= 1'b0;
      if (state_r == tsp_pkg::B_START_CHK && emit) begin
        drawing_r <= 1'b1;
        last_x_r  <= cur_x_r;
        last_y_r  <= cur_y_r;
      end
      if (cmd_pop && cmd.op == tsp_pkg::OP_HELD && drawing_r) begin
        last_x_r <= cmd.cx;
        last_y_r <= cmd.cy;
      end
      if (emit)            out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Line datapath
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == tsp_pkg::OP_HELD) begin
      tgt_x_r   <= cmd.cx;
      tgt_y_r   <= cmd.cy;
      cur_x_r   <= cmd.cx;
      cur_y_r   <= cmd.cy;
      xmajor_r  <= xmaj_c;
      dir_neg_r <= dneg_c;
      mneg_r    <= mneg_c;
      p_r       <= {1'b0, pstart_c};
      pos_r     <= {2'b00, mstart_c, {FRAC_BITS{1'b0}}};
      cnt_r     <= major_c - 1'b1;
    end
    // First intermediate: one step along both axes
    if (state_r == tsp_pkg::B_DIV && div_done) begin
      step_r <= step_c;
      pos_r  <= pos_r + {{(PW-SW){step_c[SW-1]}}, step_c};
      p_r    <= dir_neg_r ? p_r - 1'b1 : p_r + 1'b1;
    end
    if (state_r == tsp_pkg::B_STEP_RD && cand_ok) begin
      cur_x_r <= cand_x[CW-1:0];
      cur_y_r <= cand_y[CW-1:0];
    end
    if (adv) begin
      pos_r <= pos_r + {{(PW-SW){step_r[SW-1]}}, step_r};
      p_r   <= dir_neg_r ? p_r - 1'b1 : p_r + 1'b1;
      cnt_r <= cnt_r - 1'b1;
    end
    if (emit) begin
      out_cx_r   <= emit_x;
      out_cy_r   <= emit_y;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_cx     = out_cx_r;
  assign out_cy     = out_cy_r;
  assign out_last   = out_last_r;

endmodule

// File: sv/touch_stroke_line_plotter.sv
// Flow: a stroke start is popped in idle, then its cell's row is read, then checked and marked.
// A line runs the divider, then for each intermediate cell in the grid a row read, then check
// and mark; it ends by emitting the target cell as last. Release and same-cell items are popped.
// Throughput is one item at a time in the line engine; a 2-entry queue decouples input.
// rst_n (synchronous) clears control state, then a pass over all columns zeroes the canvas,
// with in_tready low; a clear item runs the same pass.
module touch_stroke_line_plotter #(
  parameter int GRID_W    = 64,
  parameter int GRID_H    = 64,
  parameter int FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [tsp_pkg::TOUCH_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tsp_pkg::IN_TDATA_W-1:0]   in_tdata,   // touch_x, touch_y
  input  logic [1:0]                       in_tuser,   // kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tsp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // cell_x, cell_y, zero pad
  output logic                             out_tlast
);

  localparam int TW = tsp_pkg::TOUCH_W;
  localparam int CW = tsp_pkg::CELL_W;

  logic          push, q_full, cmd_valid, cmd_pop, init_busy;
  tsp_pkg::cmd_t push_cmd, cmd;
  logic [CW-1:0] out_cx, out_cy;

  tsp_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_x      (in_tdata[TW-1:0]),
    .in_y      (in_tdata[2*TW-1:TW]),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tsp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (cmd_pop)
  );

  tsp_back #(.GRID_W(GRID_W), .GRID_H(GRID_H), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_cx     (out_cx),
    .out_cy     (out_cy),
    .out_last   (out_tlast)
  );

  // Pack result fields, lowest bits first
  assign out_tdata = {{(tsp_pkg::OUT_TDATA_W - 2*CW){1'b0}}, out_cy, out_cx};

endmodule

// File: sv/tsp_checker.sv
// Port-level checker for the touch stroke line plotter, bound to the top level.
// Depends on tsp_pkg and touch_stroke_line_plotter_macros.svh.
`include "touch_stroke_line_plotter_macros.svh"

module tsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  localparam int CW = tsp_pkg::CELL_W;

  // A stalled result item holds
  `TSP_CHK_NXT(a_out_hold, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata) && $stable(out_tlast),
               "result item changed while stalled")

  // Padding above the cell fields stays zero
  `TSP_CHK_IMP(a_out_pad, out_tvalid,
               out_tdata[tsp_pkg::OUT_TDATA_W-1:2*CW] == '0,
               "nonzero padding in result tdata")

  // Canvas clearing pass follows reset: no input taken right after it
  `TSP_CHK_RST(a_init_block, !rst_n, !in_tready, "input ready during canvas clearing pass")

  // Reset leaves no result pending
  `TSP_CHK_RST(a_rst_quiet, !rst_n, !out_tvalid, "result valid right after reset")

endmodule

bind touch_stroke_line_plotter tsp_checker u_tsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
